[rtl/assert_macros.svh]
// Assertion macros shared by the compare-time generator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SCT_ASSERT_CLK(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define SCT_ASSERT(label, prop, msg) \
  `SCT_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)
`else
`define SCT_ASSERT_CLK(label, clk, rstn, prop, msg)
`define SCT_ASSERT(label, prop, msg)
`endif
`endif

[rtl/sct_pkg.sv]
// Package: constants, types and helpers of the compare-time generator.
`timescale 1ns / 1ps
package sct_pkg;

  localparam int VOLT_WIDTH_DEF = 16;
  localparam int CFG_W          = 16;
  localparam int PER_W          = 16;
  localparam int TIME_W         = 15;
  localparam int SECT_W         = 3;
  localparam int K_W            = 15;
  localparam int BUS_SHIFT      = 29;
  localparam int APB_DW         = 32;
  localparam int PADDR_W        = 3;

  localparam logic [K_W-1:0]   SQRT3_Q14   = 15'd28378;
  localparam logic [CFG_W-1:0] BUS_RESET   = 16'd32767;
  localparam logic [CFG_W-1:0] PER_RESET   = 16'd1000;

  typedef enum logic {
    REG_BUS_VOLTAGE = 1'b0,
    REG_PWM_PERIOD  = 1'b1
  } sct_reg_e;

  typedef enum logic [SECT_W-1:0] {
    SECT_NULL_LO = 3'd0,
    SECT_1       = 3'd1,
    SECT_2       = 3'd2,
    SECT_3       = 3'd3,
    SECT_4       = 3'd4,
    SECT_5       = 3'd5,
    SECT_6       = 3'd6,
    SECT_NULL_HI = 3'd7
  } sct_sector_e;

  typedef struct packed {
    sct_sector_e sector;
    logic        over;
  } sct_tag_t;

  // divider operand width: covers bus << 29 and the sum of two numerators
  function automatic int div_width(input int volt_width);
    return (volt_width + 16 > CFG_W + BUS_SHIFT) ? volt_width + 16 : CFG_W + BUS_SHIFT;
  endfunction

endpackage

[rtl/sct_in_if.sv]
// Input channel: one alpha/beta voltage vector per item.
`timescale 1ns / 1ps
interface sct_in_if #(
  parameter int VOLT_WIDTH = sct_pkg::VOLT_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [VOLT_WIDTH-1:0] volt_alpha;
  logic signed [VOLT_WIDTH-1:0] volt_beta;

  modport source (output valid, volt_alpha, volt_beta, input ready);
  modport sink   (input valid, volt_alpha, volt_beta, output ready);
endinterface

[rtl/sct_out_if.sv]
// Output channel: three phase compare times, sector code and overmodulation flag.
`timescale 1ns / 1ps
interface sct_out_if;
  logic                            valid;
  logic                            ready;
  logic [sct_pkg::TIME_W-1:0]      compare_a;
  logic [sct_pkg::TIME_W-1:0]      compare_b;
  logic [sct_pkg::TIME_W-1:0]      compare_c;
  logic [sct_pkg::SECT_W-1:0]      sector_code;
  logic                            overmodulated;

  modport source (output valid, compare_a, compare_b, compare_c, sector_code,
                  overmodulated, input ready);
  modport sink   (input valid, compare_a, compare_b, compare_c, sector_code,
                  overmodulated, output ready);
endinterface

[rtl/sct_sector.sv]
// Projection and sector stages: sector code and the two active-time numerators.
`timescale 1ns / 1ps
module sct_sector #(
  parameter int VOLT_WIDTH = sct_pkg::VOLT_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  logic signed [VOLT_WIDTH-1:0] alpha_i,
  input  logic signed [VOLT_WIDTH-1:0] beta_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output logic [VOLT_WIDTH+14:0]       pf_o,
  output logic [VOLT_WIDTH+14:0]       ps_o,
  output sct_pkg::sct_sector_e         sector_o
);
  import sct_pkg::*;

  localparam int SW = VOLT_WIDTH + K_W + 1;
  localparam int PJ = VOLT_WIDTH + 17;
  localparam int PW = VOLT_WIDTH + 15;

  logic                         va_q, vb_q;
  logic                         ready_a, ready_b;
  logic signed [SW-1:0]         s_d, s_q;
  logic signed [VOLT_WIDTH-1:0] beta_q;
  logic signed [PJ-1:0]         b14, s_x, px, py, pz, f, g;
  sct_sector_e                  sect_d, sect_q;
  logic [PW-1:0]                pf_d, ps_d, pf_q, ps_q;

  assign ready_b = !vb_q || ready_i;
  assign ready_a = !va_q || ready_b;
  assign ready_o = ready_a;

  assign s_d = alpha_i * $signed({1'b0, SQRT3_Q14});

  always_comb begin
    b14    = {{3{beta_q[VOLT_WIDTH-1]}}, beta_q, 14'b0};
    s_x    = PJ'(s_q);
    px     = b14 <<< 1;
    py     = s_x + b14;
    pz     = b14 - s_x;
    sect_d = sct_sector_e'({py[PJ-1], pz[PJ-1],
                            (!beta_q[VOLT_WIDTH-1] && (beta_q != '0))});
    unique case (sect_d)
      SECT_1: begin
        f = pz;
        g = py;
      end
      SECT_2: begin
        f = py;
        g = -px;
      end
      SECT_3: begin
        f = -pz;
        g = px;
      end
      SECT_4: begin
        f = -px;
        g = pz;
      end
      SECT_5: begin
        f = px;
        g = -py;
      end
      SECT_6: begin
        f = -py;
        g = -pz;
      end
      default: begin
        f = '0;
        g = '0;
      end
    endcase
    pf_d = f[PJ-1] ? '0 : f[PW-1:0];
    ps_d = g[PJ-1] ? '0 : g[PW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (ready_a) va_q <= valid_i;
      if (ready_b) vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_a && valid_i) begin
      s_q    <= s_d;
      beta_q <= beta_i;
    end
    if (ready_b && va_q) begin
      pf_q   <= pf_d;
      ps_q   <= ps_d;
      sect_q <= sect_d;
    end
  end

  assign valid_o  = vb_q;
  assign pf_o     = pf_q;
  assign ps_o     = ps_q;
  assign sector_o = sect_q;

endmodule

[rtl/sct_scale.sv]
// Scaling stages: sqrt3 products, overmodulation test and divider operand select.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sct_scale #(
  parameter int VOLT_WIDTH = sct_pkg::VOLT_WIDTH_DEF
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       valid_i,
  output logic                                       ready_o,
  input  logic [VOLT_WIDTH+14:0]                     pf_i,
  input  logic [VOLT_WIDTH+14:0]                     ps_i,
  input  sct_pkg::sct_sector_e                       sector_i,
  input  logic [sct_pkg::CFG_W-1:0]                  bus_i,
  input  logic [sct_pkg::CFG_W-1:0]                  per_i,
  output logic                                       valid_o,
  input  logic                                       ready_i,
  output logic [sct_pkg::div_width(VOLT_WIDTH)-1:0]  den_o,
  output logic [sct_pkg::div_width(VOLT_WIDTH)-1:0]  num1_o,
  output logic [sct_pkg::div_width(VOLT_WIDTH)-1:0]  num2_o,
  output sct_pkg::sct_tag_t                          tag_o
);
  import sct_pkg::*;

  localparam int PW = VOLT_WIDTH + 15;
  localparam int MW = VOLT_WIDTH + 30;
  localparam int DW = div_width(VOLT_WIDTH);
  localparam int BW = CFG_W + BUS_SHIFT;
  localparam int CW = (MW + 1 > BW) ? MW + 1 : BW;

  logic              vc_q, vd_q;
  logic              ready_c, ready_d;
  logic [MW-1:0]     m1_d, m2_d, m1_q, m2_q;
  logic [PW-1:0]     pf_q, ps_q;
  sct_sector_e       sect_q;
  logic [CW-1:0]     msum, bus_sh;
  logic              over;
  logic [DW-1:0]     den_d, n1_d, n2_d, den_q, n1_q, n2_q;
  sct_tag_t          tag_d, tag_q;

  assign ready_d = !vd_q || ready_i;
  assign ready_c = !vc_q || ready_d;
  assign ready_o = ready_c;

  assign m1_d = MW'(pf_i) * MW'(SQRT3_Q14);
  assign m2_d = MW'(ps_i) * MW'(SQRT3_Q14);

  always_comb begin
    msum   = CW'(m1_q) + CW'(m2_q);
    bus_sh = CW'({bus_i, {BUS_SHIFT{1'b0}}});
    over   = (per_i != '0) && (msum > bus_sh);
    if (over) begin
      den_d = DW'(pf_q) + DW'(ps_q);
      n1_d  = DW'(pf_q);
      n2_d  = DW'(ps_q);
    end else if (bus_i != '0 && per_i != '0) begin
      den_d = DW'({bus_i, {BUS_SHIFT{1'b0}}});
      n1_d  = DW'(m1_q);
      n2_d  = DW'(m2_q);
    end else begin
      den_d = DW'(1);
      n1_d  = '0;
      n2_d  = '0;
    end
    tag_d.sector = sect_q;
    tag_d.over   = over;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else begin
      if (ready_c) vc_q <= valid_i;
      if (ready_d) vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_c && valid_i) begin
      m1_q   <= m1_d;
      m2_q   <= m2_d;
      pf_q   <= pf_i;
      ps_q   <= ps_i;
      sect_q <= sector_i;
    end
    if (ready_d && vc_q) begin
      den_q <= den_d;
      n1_q  <= n1_d;
      n2_q  <= n2_d;
      tag_q <= tag_d;
    end
  end

  assign valid_o = vd_q;
  assign den_o   = den_q;
  assign num1_o  = n1_q;
  assign num2_o  = n2_q;
  assign tag_o   = tag_q;

  `SCT_ASSERT(a_num_fits, vd_q |-> (n1_q <= den_q && n2_q <= den_q && den_q != '0), "numerator above divisor")

endmodule

[rtl/sct_div_step.sv]
// One radix-2 step of the two active-time dividers: floor(period * num / den).
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sct_div_step #(
  parameter int VOLT_WIDTH = sct_pkg::VOLT_WIDTH_DEF
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      valid_i,
  output logic                                      ready_o,
  input  logic                                      per_bit_i,
  input  logic [sct_pkg::div_width(VOLT_WIDTH)-1:0] den_i,
  input  logic [sct_pkg::div_width(VOLT_WIDTH)-1:0] num1_i,
  input  logic [sct_pkg::div_width(VOLT_WIDTH)-1:0] num2_i,
  input  logic [sct_pkg::div_width(VOLT_WIDTH)-1:0] rem1_i,
  input  logic [sct_pkg::div_width(VOLT_WIDTH)-1:0] rem2_i,
  input  logic [sct_pkg::PER_W-1:0]                 quo1_i,
  input  logic [sct_pkg::PER_W-1:0]                 quo2_i,
  input  sct_pkg::sct_tag_t                         tag_i,
  output logic                                      valid_o,
  input  logic                                      ready_i,
  output logic [sct_pkg::div_width(VOLT_WIDTH)-1:0] den_o,
  output logic [sct_pkg::div_width(VOLT_WIDTH)-1:0] num1_o,
  output logic [sct_pkg::div_width(VOLT_WIDTH)-1:0] num2_o,
  output logic [sct_pkg::div_width(VOLT_WIDTH)-1:0] rem1_o,
  output logic [sct_pkg::div_width(VOLT_WIDTH)-1:0] rem2_o,
  output logic [sct_pkg::PER_W-1:0]                 quo1_o,
  output logic [sct_pkg::PER_W-1:0]                 quo2_o,
  output sct_pkg::sct_tag_t                         tag_o
);
  import sct_pkg::*;

  localparam int DW = div_width(VOLT_WIDTH);

  // returns {digit, remainder}; digit is 0..2 since rem < den and num <= den
  function automatic logic [DW+1:0] div_digit(input logic [DW-1:0] rem,
                                              input logic [DW-1:0] num,
                                              input logic [DW-1:0] den,
                                              input logic          b);
    logic [DW+1:0] t, d1, d2, res;
    t  = {1'b0, rem, 1'b0} + (b ? {2'b00, num} : '0);
    d1 = {2'b00, den};
    d2 = {1'b0, den, 1'b0};
    priority if (t >= d2) res = {2'd2, DW'(t - d2)};
    else if (t >= d1)     res = {2'd1, DW'(t - d1)};
    else                  res = {2'd0, DW'(t)};
    return res;
  endfunction

  logic              v_q;
  logic [DW+1:0]     s1, s2;
  logic [DW-1:0]     den_q, n1_q, n2_q, rem1_q, rem2_q;
  logic [PER_W-1:0]  quo1_q, quo2_q;
  sct_tag_t          tag_q;

  assign ready_o = !v_q || ready_i;
  assign s1      = div_digit(rem1_i, num1_i, den_i, per_bit_i);
  assign s2      = div_digit(rem2_i, num2_i, den_i, per_bit_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      den_q  <= den_i;
      n1_q   <= num1_i;
      n2_q   <= num2_i;
      rem1_q <= s1[DW-1:0];
      rem2_q <= s2[DW-1:0];
      quo1_q <= {quo1_i[PER_W-2:0], 1'b0} + PER_W'(s1[DW+1:DW]);
      quo2_q <= {quo2_i[PER_W-2:0], 1'b0} + PER_W'(s2[DW+1:DW]);
      tag_q  <= tag_i;
    end
  end

  assign valid_o = v_q;
  assign den_o   = den_q;
  assign num1_o  = n1_q;
  assign num2_o  = n2_q;
  assign rem1_o  = rem1_q;
  assign rem2_o  = rem2_q;
  assign quo1_o  = quo1_q;
  assign quo2_o  = quo2_q;
  assign tag_o   = tag_q;

  `SCT_ASSERT(a_rem_below_den, v_q |-> (rem1_q < den_q && rem2_q < den_q), "divider remainder not below divisor")

endmodule

[rtl/sct_timing.sv]
// Output stage: seven-segment compare times per sector, output register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sct_timing (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  logic [sct_pkg::PER_W-1:0]    t1_i,
  input  logic [sct_pkg::PER_W-1:0]    t2_i,
  input  logic [sct_pkg::CFG_W-1:0]    per_i,
  input  sct_pkg::sct_tag_t            tag_i,
  sct_out_if.source                    out_if
);
  import sct_pkg::*;

  localparam int QW = PER_W + 2;

  logic              v_q;
  logic [QW-1:0]     qn, tbn, tcn;
  logic [TIME_W-1:0] ta, tb, tc, ca_d, cb_d, cc_d, ca_q, cb_q, cc_q;
  sct_sector_e       sect_q;
  logic              over_q;

  assign ready_o = !v_q || out_if.ready;

  always_comb begin
    qn  = QW'(per_i) - QW'(t1_i) - QW'(t2_i);
    tbn = qn + QW'({t1_i, 1'b0});
    tcn = tbn + QW'({t2_i, 1'b0});
    ta  = qn[TIME_W+1:2];
    tb  = tbn[TIME_W+1:2];
    tc  = tcn[TIME_W+1:2];
    unique case (tag_i.sector)
      SECT_1: begin
        ca_d = tb; cb_d = ta; cc_d = tc;
      end
      SECT_2: begin
        ca_d = ta; cb_d = tc; cc_d = tb;
      end
      SECT_3: begin
        ca_d = ta; cb_d = tb; cc_d = tc;
      end
      SECT_4: begin
        ca_d = tc; cb_d = tb; cc_d = ta;
      end
      SECT_5: begin
        ca_d = tc; cb_d = ta; cc_d = tb;
      end
      SECT_6: begin
        ca_d = tb; cb_d = tc; cc_d = ta;
      end
      default: begin
        ca_d = '0; cb_d = '0; cc_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      ca_q   <= ca_d;
      cb_q   <= cb_d;
      cc_q   <= cc_d;
      sect_q <= tag_i.sector;
      over_q <= tag_i.over;
    end
  end

  assign out_if.valid         = v_q;
  assign out_if.compare_a     = ca_q;
  assign out_if.compare_b     = cb_q;
  assign out_if.compare_c     = cc_q;
  assign out_if.sector_code   = sect_q;
  assign out_if.overmodulated = over_q;

  `SCT_ASSERT(a_times_fit, valid_i |-> (({1'b0, t1_i} + {1'b0, t2_i}) <= {1'b0, per_i}), "active times exceed period")
  `SCT_ASSERT(a_null_zero, v_q && (sect_q == SECT_NULL_LO || sect_q == SECT_NULL_HI) |-> (ca_q == '0 && cb_q == '0 && cc_q == '0 && !over_q), "null vector with nonzero output")

endmodule

[rtl/svpwm_compare_times.sv]
// Top level: space-vector PWM compare-time generator with APB register port.
// Usage:
//   in_if carries one alpha/beta voltage vector per item (valid/ready);
//   out_if returns one item per input: compare_a/b/c for a center-aligned
//   seven-segment pattern, the sector code and the overmodulation flag.
//   Registers over APB: bus_voltage at 0x0, pwm_period at 0x4; write them
//   only while no item is in flight. pready is tied high.
// Pipeline:
//   Two projection/sector stages, two scaling stages, 16 divider stages (one
//   quotient bit of the period per stage) and the output register. One item
//   per cycle is sustained while the output is not stalled.
// Reset:
//   rst_ni clears all valid bits and loads bus_voltage 32767, period 1000.
// Back-pressure:
//   Each stage holds its item while the next one is full and stalled; empty
//   stages keep filling, so in_if.ready drops only once the pipeline is full.
`timescale 1ns / 1ps
module svpwm_compare_times #(
  parameter int VOLT_WIDTH = sct_pkg::VOLT_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sct_pkg::PADDR_W-1:0]   paddr,
  input  logic [sct_pkg::APB_DW-1:0]    pwdata,
  output logic [sct_pkg::APB_DW-1:0]    prdata,
  output logic                          pready,
  sct_in_if.sink                        in_if,
  sct_out_if.source                     out_if
);
  import sct_pkg::*;

  localparam int PW = VOLT_WIDTH + 15;
  localparam int DW = div_width(VOLT_WIDTH);

  logic [CFG_W-1:0]  bus_q, per_q;
  sct_reg_e          reg_sel;

  logic              sec_valid, sec_ready;
  logic [PW-1:0]     sec_pf, sec_ps;
  sct_sector_e       sec_sect;

  logic              dv    [PER_W+1];
  logic              dr    [PER_W+1];
  logic [DW-1:0]     dden  [PER_W+1];
  logic [DW-1:0]     dn1   [PER_W+1];
  logic [DW-1:0]     dn2   [PER_W+1];
  logic [DW-1:0]     drem1 [PER_W+1];
  logic [DW-1:0]     drem2 [PER_W+1];
  logic [PER_W-1:0]  dq1   [PER_W+1];
  logic [PER_W-1:0]  dq2   [PER_W+1];
  sct_tag_t          dtag  [PER_W+1];

  // register port
  assign reg_sel = sct_reg_e'(paddr[2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bus_q <= BUS_RESET;
      per_q <= PER_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_BUS_VOLTAGE: bus_q <= pwdata[CFG_W-1:0];
        REG_PWM_PERIOD:  per_q <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_BUS_VOLTAGE: prdata = APB_DW'(bus_q);
      REG_PWM_PERIOD:  prdata = APB_DW'(per_q);
      default:         prdata = '0;
    endcase
  end

  sct_sector #(.VOLT_WIDTH(VOLT_WIDTH)) u_sector (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_if.valid),
    .ready_o  (in_if.ready),
    .alpha_i  (in_if.volt_alpha),
    .beta_i   (in_if.volt_beta),
    .valid_o  (sec_valid),
    .ready_i  (sec_ready),
    .pf_o     (sec_pf),
    .ps_o     (sec_ps),
    .sector_o (sec_sect)
  );

  sct_scale #(.VOLT_WIDTH(VOLT_WIDTH)) u_scale (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (sec_valid),
    .ready_o  (sec_ready),
    .pf_i     (sec_pf),
    .ps_i     (sec_ps),
    .sector_i (sec_sect),
    .bus_i    (bus_q),
    .per_i    (per_q),
    .valid_o  (dv[0]),
    .ready_i  (dr[0]),
    .den_o    (dden[0]),
    .num1_o   (dn1[0]),
    .num2_o   (dn2[0]),
    .tag_o    (dtag[0])
  );

  assign drem1[0] = '0;
  assign drem2[0] = '0;
  assign dq1[0]   = '0;
  assign dq2[0]   = '0;

  for (genvar k = 0; k < PER_W; k++) begin : g_div
    sct_div_step #(.VOLT_WIDTH(VOLT_WIDTH)) u_step (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .valid_i   (dv[k]),
      .ready_o   (dr[k]),
      .per_bit_i (per_q[PER_W-1-k]),
      .den_i     (dden[k]),
      .num1_i    (dn1[k]),
      .num2_i    (dn2[k]),
      .rem1_i    (drem1[k]),
      .rem2_i    (drem2[k]),
      .quo1_i    (dq1[k]),
      .quo2_i    (dq2[k]),
      .tag_i     (dtag[k]),
      .valid_o   (dv[k+1]),
      .ready_i   (dr[k+1]),
      .den_o     (dden[k+1]),
      .num1_o    (dn1[k+1]),
      .num2_o    (dn2[k+1]),
      .rem1_o    (drem1[k+1]),
      .rem2_o    (drem2[k+1]),
      .quo1_o    (dq1[k+1]),
      .quo2_o    (dq2[k+1]),
      .tag_o     (dtag[k+1])
    );
  end

  sct_timing u_timing (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dv[PER_W]),
    .ready_o (dr[PER_W]),
    .t1_i    (dq1[PER_W]),
    .t2_i    (dq2[PER_W]),
    .per_i   (per_q),
    .tag_i   (dtag[PER_W]),
    .out_if  (out_if)
  );

endmodule

[verif/sct_check.sv]
// Checker: predicts compare times from accepted vectors and compares each output item.
`timescale 1ns / 1ps
module sct_check (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [sct_pkg::PADDR_W-1:0] paddr,
  input  logic [sct_pkg::APB_DW-1:0]  pwdata,
  sct_in_if                           in_mon,
  sct_out_if                          out_mon,
  output int                          errors_o,
  output int                          pending_o
);
  import sct_pkg::*;

  localparam longint unsigned ROOT3 = 28378;

  typedef struct packed {
    logic [TIME_W-1:0] ta;
    logic [TIME_W-1:0] tb;
    logic [TIME_W-1:0] tc;
    sct_sector_e       sector;
    logic              over;
  } compare_t;

  compare_t         expected_q[$];
  logic [CFG_W-1:0] bus_v;
  logic [CFG_W-1:0] period;
  int               errors;

  assign errors_o  = errors;
  assign pending_o = expected_q.size();

  function automatic compare_t compare_times(input logic signed [15:0] al,
                                             input logic signed [15:0] be,
                                             input logic [CFG_W-1:0] bus,
                                             input logic [CFG_W-1:0] per);
    longint            s, b14, px, py, pz, f, g;
    logic [127:0]      pf, ps, sum, t1, t2, q, den, per_w;
    logic [127:0]      ta, tb, tc, ca, cb, cc;
    logic [2:0]        n;
    compare_t          r;
    s     = longint'(al) * 28378;
    b14   = longint'(be) * 16384;
    px    = 2 * b14;
    py    = s + b14;
    pz    = b14 - s;
    n     = {(-s - b14) > 0, (s - b14) > 0, be > 0};
    f     = 0;
    g     = 0;
    t1    = 0;
    t2    = 0;
    ca    = 0;
    cb    = 0;
    cc    = 0;
    per_w = per;
    r.over = 1'b0;
    case (sct_sector_e'(n))
      SECT_1: begin f = pz;  g = py;  end
      SECT_2: begin f = py;  g = -px; end
      SECT_3: begin f = -pz; g = px;  end
      SECT_4: begin f = -px; g = pz;  end
      SECT_5: begin f = px;  g = -py; end
      SECT_6: begin f = -py; g = -pz; end
      default: ;
    endcase
    if (n >= 1 && n <= 6) begin
      pf  = (f > 0) ? f : 0;
      ps  = (g > 0) ? g : 0;
      sum = pf + ps;
      den = 128'(bus) << 29;
      if (per != 0 && ROOT3 * sum > den) begin
        r.over = 1'b1;
        t1 = per_w * pf / sum;
        t2 = per_w * ps / sum;
      end else if (bus != 0) begin
        t1 = ROOT3 * pf * per_w / den;
        t2 = ROOT3 * ps * per_w / den;
      end
      if (t1 + t2 > per_w) begin
        t1 = 0;
        t2 = 0;
      end
      q  = per_w - t1 - t2;
      ta = q / 4;
      tb = (q + 2 * t1) / 4;
      tc = (q + 2 * t1 + 2 * t2) / 4;
      case (sct_sector_e'(n))
        SECT_1:  begin ca = tb; cb = ta; cc = tc; end
        SECT_2:  begin ca = ta; cb = tc; cc = tb; end
        SECT_3:  begin ca = ta; cb = tb; cc = tc; end
        SECT_4:  begin ca = tc; cb = tb; cc = ta; end
        SECT_5:  begin ca = tc; cb = ta; cc = tb; end
        default: begin ca = tb; cb = tc; cc = ta; end
      endcase
    end
    r.ta     = ca[TIME_W-1:0];
    r.tb     = cb[TIME_W-1:0];
    r.tc     = cc[TIME_W-1:0];
    r.sector = sct_sector_e'(n);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    compare_t e;
    if (!rst_ni) begin
      bus_v  <= BUS_RESET;
      period <= PER_RESET;
      errors <= 0;
      expected_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == 3'(REG_BUS_VOLTAGE) * 4) bus_v <= pwdata[CFG_W-1:0];
        if (paddr == 3'(REG_PWM_PERIOD) * 4)  period <= pwdata[CFG_W-1:0];
      end
      if (in_mon.valid && in_mon.ready)
        expected_q.push_back(compare_times(in_mon.volt_alpha, in_mon.volt_beta, bus_v,
                                           period));
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected item a=%0d b=%0d c=%0d n=%0d ovm=%0b", $time,
                   out_mon.compare_a, out_mon.compare_b, out_mon.compare_c,
                   out_mon.sector_code, out_mon.overmodulated);
          errors <= errors + 1;
        end else begin
          e = expected_q.pop_front();
          if (out_mon.compare_a !== e.ta || out_mon.compare_b !== e.tb ||
              out_mon.compare_c !== e.tc || out_mon.sector_code !== e.sector ||
              out_mon.overmodulated !== e.over) begin
            $display("%0t: mismatch expected a=%0d b=%0d c=%0d n=%0d ovm=%0b", $time,
                     e.ta, e.tb, e.tc, e.sector, e.over);
            $display("%0t:          actual   a=%0d b=%0d c=%0d n=%0d ovm=%0b", $time,
                     out_mon.compare_a, out_mon.compare_b, out_mon.compare_c,
                     out_mon.sector_code, out_mon.overmodulated);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

[verif/tb.sv]
// Testbench top: drives vectors, registers and back-pressure, and reports the verdict.
`timescale 1ns / 1ps
module tb;
  import sct_pkg::*;

  localparam int WATCHDOG = 3000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [APB_DW-1:0]   pwdata = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;
  int                  errors;
  int                  pending;
  int                  quiet;
  bit                  idle_en = 1'b1;
  bit                  long_hold = 1'b0;

  sct_in_if  in_if ();
  sct_out_if out_if ();

  svpwm_compare_times dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_if(in_if), .out_if(out_if)
  );

  sct_check check (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .in_mon(in_if), .out_mon(out_if), .errors_o(errors), .pending_o(pending)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    in_if.valid      = 1'b0;
    in_if.volt_alpha = '0;
    in_if.volt_beta  = '0;
    out_if.ready     = 1'b0;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      quiet <= 0;
    else if (quiet >= WATCHDOG) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else
      quiet <= quiet + 1;
  end

  // receiver back-pressure
  initial begin
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (long_hold) begin
        out_if.ready <= 1'b0;
        repeat (150) @(posedge clk_i);
        long_hold = 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end else begin
        out_if.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  task automatic send_vector(input logic [15:0] al, input logic [15:0] be);
    in_if.valid      <= 1'b1;
    in_if.volt_alpha <= al;
    in_if.volt_beta  <= be;
    do @(posedge clk_i); while (!in_if.ready);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  endtask

  task automatic drain;
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic reg_write(input sct_reg_e idx, input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(int'(idx) * 4);
    pwdata  <= APB_DW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic random_vectors(input int count);
    logic [15:0] al, be;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) < 7) begin
        al = $urandom;
        be = $urandom;
      end else begin
        al = 16'($signed($urandom_range(0, 4000)) - 2000);
        be = 16'($signed($urandom_range(0, 4000)) - 2000);
      end
      send_vector(al, be);
    end
  endtask

  initial begin
    logic [15:0] edge_vals[8];
    edge_vals = '{16'h8000, 16'h7FFF, 16'h0000, 16'h0001, 16'hFFFF, 16'h4000, 16'hC000,
                  16'h5555};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset values, directed extremes and every sector
    for (int i = 0; i < 5; i++)
      for (int j = 0; j < 5; j++)
        send_vector(edge_vals[i], edge_vals[j]);
    random_vectors(300);

    // receiver holds off while the sender keeps going
    long_hold = 1'b1;
    random_vectors(60);
    drain();

    reg_write(REG_BUS_VOLTAGE, 16'd1);
    reg_write(REG_PWM_PERIOD, 16'd65535);
    random_vectors(300);
    drain();

    reg_write(REG_BUS_VOLTAGE, 16'd65535);
    reg_write(REG_PWM_PERIOD, 16'd1);
    random_vectors(250);
    drain();

    reg_write(REG_BUS_VOLTAGE, 16'd65535);
    reg_write(REG_PWM_PERIOD, 16'd65535);
    random_vectors(300);
    drain();

    reg_write(REG_BUS_VOLTAGE, 16'($urandom_range(1000, 65535)));
    reg_write(REG_PWM_PERIOD, 16'($urandom_range(1, 65535)));
    random_vectors(300);
    drain();

    reg_write(REG_BUS_VOLTAGE, 16'd32767);
    reg_write(REG_PWM_PERIOD, 16'd8000);
    idle_en = 1'b0;
    random_vectors(300);
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (40) @(posedge clk_i);

    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
